// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/abdf_pkg.sv -----
// Shared constants, types and field layout for the anchor box decode filter.
package abdf_pkg;

	localparam int CLASS_COUNT = 4;
	// Only the score fields that exist can take part.
	localparam int CLASS_USED = (CLASS_COUNT < 1) ? 1 : ((CLASS_COUNT > 4) ? 4 : CLASS_COUNT);
	localparam int SCORE_FIELDS = 4;

	localparam int ANCHOR_W = 14;
	localparam int COORD_W = 16;
	localparam int SCORE_W = 16;
	localparam int SCALE_W = 16;
	localparam int PIX_W = 12;
	localparam int CLASS_W = 2;
	localparam int EDGE_W = 14;
	localparam int SPAN_W = 15;
	localparam int AREA_W = 2 * PIX_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam int HARD_MIN_SIDE = 2;

	// Input tdata layout, lowest bit first.
	localparam int IN_ANCHOR_LO = 0;
	localparam int IN_CX_LO = IN_ANCHOR_LO + ANCHOR_W;
	localparam int IN_CY_LO = IN_CX_LO + COORD_W;
	localparam int IN_BW_LO = IN_CY_LO + COORD_W;
	localparam int IN_BH_LO = IN_BW_LO + COORD_W;
	localparam int IN_SCORE_LO = IN_BH_LO + COORD_W;
	localparam int IN_BITS = IN_SCORE_LO + SCORE_FIELDS * SCORE_W;
	localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;

	localparam int OUT_BITS = ANCHOR_W + CLASS_W + SCORE_W + 4 * PIX_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_CONF_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_SCALE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_SCALE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_BOX_SIDE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_BOX_AREA = 3'd6;

	// Per-stage load enables of the pipeline.
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic so;
	} stage_ld_t;

endpackage

// ----- rtl/abdf_axis.sv -----
// One axis of the box decode: scale centre and size, then clamp to the image.
module abdf_axis (
	input  logic                             clk,
	input  abdf_pkg::stage_ld_t              ld,
	input  logic [abdf_pkg::COORD_W-1:0]     centre,
	input  logic [abdf_pkg::COORD_W-1:0]     size,
	input  logic [abdf_pkg::SCALE_W-1:0]     scale,
	input  logic [abdf_pkg::PIX_W-1:0]       limit,
	output logic [abdf_pkg::EDGE_W-1:0]      edge_s3,
	output logic signed [abdf_pkg::SPAN_W-1:0] span_s3
);
	import abdf_pkg::*;

	localparam int DIFF_W = COORD_W + 2;
	localparam int EPROD_W = (COORD_W + 1) + SCALE_W;
	localparam int SPROD_W = COORD_W + SCALE_W;

	logic signed [DIFF_W-1:0] diff_s1;
	logic [COORD_W-1:0]       size_s1;
	logic [EPROD_W-1:0]       eprod_s2;
	logic [SPROD_W-1:0]       sprod_s2;
	logic signed [SPAN_W-1:0] lim;
	logic signed [SPAN_W-1:0] span_raw;
	logic [EDGE_W-1:0]        edge_raw;

	// 2*centre - size, one fraction bit more than the inputs
	always_ff @(posedge clk) begin
		if (ld.s1) begin
			diff_s1 <= $signed({1'b0, centre, 1'b0}) - $signed({2'b00, size});
			size_s1 <= size;
		end
	end

	// A non-positive edge clamps to zero, so its product is forced to zero.
	always_ff @(posedge clk) begin
		if (ld.s2) begin
			if (diff_s1 > 0)
				eprod_s2 <= diff_s1[COORD_W:0] * scale;
			else
				eprod_s2 <= '0;
			sprod_s2 <= size_s1 * scale;
		end
	end

	assign edge_raw = eprod_s2[EPROD_W-1 -: EDGE_W];
	assign span_raw = $signed({1'b0, sprod_s2[SPROD_W-1 -: EDGE_W]});
	assign lim = $signed({{(SPAN_W-PIX_W){1'b0}}, limit}) -
		$signed({{(SPAN_W-EDGE_W){1'b0}}, edge_raw});

	always_ff @(posedge clk) begin
		if (ld.s3) begin
			edge_s3 <= edge_raw;
			span_s3 <= (span_raw > lim) ? lim : span_raw;
		end
	end

endmodule

// ----- rtl/detector_anchor_box_decode_filter_unit.sv -----
// Top level: anchor row argmax, confidence filter, box decode, clamp and size filter.
//
//  channel  | direction | transfer contents
//  s_axis   | in        | one anchor row: index, centre, size, four class scores
//  m_axis   | out       | one kept box: anchor, class, confidence, corner box
//  cfg      | in        | register write, index 0..6, no read-back
//
// Five register stages (argmax and edge offset, products, clamp, side test and
// area product, output register); one row can enter every cycle unless a stall
// on m_axis has filled the stages. Dropped rows leave bubbles, not results.
// Each stage loads when it is empty or the stage after it loads, so a stall on
// m_axis fills bubbles first and loses nothing. arst_n clears valid bits and
// puts the configuration registers at their defaults.
module detector_anchor_box_decode_filter_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// anchor_index, centre_x, centre_y, box_w, box_h, score_0..score_3, zero pad
	input  logic [abdf_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// kept_anchor, winning class, confidence, box_left, box_top, box_width, box_height
	output logic [abdf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  logic                                cfg_we,
	input  logic [abdf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [abdf_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import abdf_pkg::*;

	// configuration registers
	logic [SCORE_W-1:0] conf_threshold_q;
	logic [SCALE_W-1:0] x_scale_q;
	logic [SCALE_W-1:0] y_scale_q;
	logic [PIX_W-1:0]   image_width_q;
	logic [PIX_W-1:0]   image_height_q;
	logic [PIX_W-1:0]   min_box_side_q;
	logic [SCORE_W-1:0] min_box_area_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_threshold_q <= 16'd16384;
			x_scale_q        <= 16'd4096;
			y_scale_q        <= 16'd4096;
			image_width_q    <= 12'd640;
			image_height_q   <= 12'd640;
			min_box_side_q   <= 12'd6;
			min_box_area_q   <= 16'd120;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CONF_THRESHOLD: conf_threshold_q <= cfg_data;
				REG_X_SCALE:        x_scale_q <= cfg_data;
				REG_Y_SCALE:        y_scale_q <= cfg_data;
				REG_IMAGE_WIDTH:    image_width_q <= cfg_data[PIX_W-1:0];
				REG_IMAGE_HEIGHT:   image_height_q <= cfg_data[PIX_W-1:0];
				REG_MIN_BOX_SIDE:   min_box_side_q <= cfg_data[PIX_W-1:0];
				REG_MIN_BOX_AREA:   min_box_area_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control
	logic      v_s1, v_s2, v_s3, v_s4, out_valid_q;
	stage_ld_t ld;

	assign ld.so = !out_valid_q || m_axis_tready;
	assign ld.s4 = !v_s4 || ld.so;
	assign ld.s3 = !v_s3 || ld.s4;
	assign ld.s2 = !v_s2 || ld.s3;
	assign ld.s1 = !v_s1 || ld.s2;
	assign s_axis_tready = ld.s1;

	// argmax over the used classes, first highest wins
	logic [SCORE_W-1:0] best;
	logic [CLASS_W-1:0] win_cls;
	logic               conf_ok;

	always_comb begin
		best = s_axis_tdata[IN_SCORE_LO +: SCORE_W];
		win_cls = '0;
		for (int c = 1; c < CLASS_USED; c++) begin
			if (s_axis_tdata[IN_SCORE_LO + c*SCORE_W +: SCORE_W] > best) begin
				best = s_axis_tdata[IN_SCORE_LO + c*SCORE_W +: SCORE_W];
				win_cls = CLASS_W'(c);
			end
		end
	end

	assign conf_ok = best >= conf_threshold_q;

	// payload carried alongside the axis datapaths
	logic [ANCHOR_W-1:0] anchor_s1, anchor_s2, anchor_s3, anchor_s4;
	logic [CLASS_W-1:0]  cls_s1, cls_s2, cls_s3, cls_s4;
	logic [SCORE_W-1:0]  conf_s1, conf_s2, conf_s3, conf_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ld.s1) v_s1 <= s_axis_tvalid && conf_ok;
			if (ld.s2) v_s2 <= v_s1;
			if (ld.s3) v_s3 <= v_s2;
			if (ld.s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.s1) begin
			anchor_s1 <= s_axis_tdata[IN_ANCHOR_LO +: ANCHOR_W];
			cls_s1    <= win_cls;
			conf_s1   <= best;
		end
		if (ld.s2) begin
			anchor_s2 <= anchor_s1;
			cls_s2    <= cls_s1;
			conf_s2   <= conf_s1;
		end
		if (ld.s3) begin
			anchor_s3 <= anchor_s2;
			cls_s3    <= cls_s2;
			conf_s3   <= conf_s2;
		end
		if (ld.s4) begin
			anchor_s4 <= anchor_s3;
			cls_s4    <= cls_s3;
			conf_s4   <= conf_s3;
		end
	end

	logic [EDGE_W-1:0]        left_s3, top_s3;
	logic signed [SPAN_W-1:0] width_s3, height_s3;

	abdf_axis u_axis_x (
		.clk     (clk),
		.ld      (ld),
		.centre  (s_axis_tdata[IN_CX_LO +: COORD_W]),
		.size    (s_axis_tdata[IN_BW_LO +: COORD_W]),
		.scale   (x_scale_q),
		.limit   (image_width_q),
		.edge_s3 (left_s3),
		.span_s3 (width_s3)
	);

	abdf_axis u_axis_y (
		.clk     (clk),
		.ld      (ld),
		.centre  (s_axis_tdata[IN_CY_LO +: COORD_W]),
		.size    (s_axis_tdata[IN_BH_LO +: COORD_W]),
		.scale   (y_scale_q),
		.limit   (image_height_q),
		.edge_s3 (top_s3),
		.span_s3 (height_s3)
	);

	// side tests; the area product only matters when both sides pass
	logic signed [SPAN_W-1:0] min_side;
	logic signed [SPAN_W-1:0] hard_min;
	logic                     side_ok;
	logic                     side_ok_s4;
	logic [AREA_W-1:0]        area_s4;
	logic [PIX_W-1:0]         left_s4, top_s4, width_s4, height_s4;

	assign min_side = $signed({{(SPAN_W-PIX_W){1'b0}}, min_box_side_q});
	assign hard_min = SPAN_W'(HARD_MIN_SIDE);
	assign side_ok = (width_s3 >= min_side) && (height_s3 >= min_side) &&
		(width_s3 >= hard_min) && (height_s3 >= hard_min);

	always_ff @(posedge clk) begin
		if (ld.s4) begin
			side_ok_s4 <= side_ok;
			area_s4    <= width_s3[PIX_W-1:0] * height_s3[PIX_W-1:0];
			left_s4    <= left_s3[PIX_W-1:0];
			top_s4     <= top_s3[PIX_W-1:0];
			width_s4   <= width_s3[PIX_W-1:0];
			height_s4  <= height_s3[PIX_W-1:0];
		end
	end

	logic                  keep;
	logic [OUT_DATA_W-1:0] out_data_q;

	assign keep = v_s4 && side_ok_s4 &&
		(area_s4 >= {{(AREA_W-SCORE_W){1'b0}}, min_box_area_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ld.so)
			out_valid_q <= keep;
	end

	always_ff @(posedge clk) begin
		if (ld.so)
			out_data_q <= OUT_DATA_W'({height_s4, width_s4, top_s4, left_s4,
				conf_s4, cls_s4, anchor_s4});
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// ----- rtl/abdf_checker.sv -----
// Port-level checker for the anchor box decode filter, bound to the top level.
`include "assert_macros.svh"

module abdf_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_axis_tvalid,
	input logic                                s_axis_tready,
	input logic [abdf_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [abdf_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
	import abdf_pkg::*;

	localparam int W_LO = ANCHOR_W + CLASS_W + SCORE_W + 2 * PIX_W;
	localparam int H_LO = W_LO + PIX_W;

	logic [PIX_W-1:0] out_w, out_h;
	logic             in_seen;

	assign out_w = m_axis_tdata[W_LO +: PIX_W];
	assign out_h = m_axis_tdata[H_LO +: PIX_W];
	assign in_seen = s_axis_tvalid || (s_axis_tdata != '0);

	// An empty output stage means the whole pipe can take a row.
	`CHK_SAME(a_ready_when_out_empty, clk, arst_n, !m_axis_tvalid, s_axis_tready, "input stalled with output empty")
	// Every kept box is at least two pixels on each side.
	`CHK_SAME(a_min_side, clk, arst_n, m_axis_tvalid, (out_w >= PIX_W'(HARD_MIN_SIDE)) && (out_h >= PIX_W'(HARD_MIN_SIDE)), "kept box below hard minimum side")
	// A stalled result holds.
	`CHK_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
	// Nothing comes out right after reset without an earlier row.
	`CHK_NEXT(a_no_early_out, clk, arst_n, $rose(arst_n) && !in_seen, !m_axis_tvalid, "result without input after reset")

endmodule

bind detector_anchor_box_decode_filter_unit abdf_checker u_abdf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
